// ===== hw/rtl/fir_fast_convolution_defines.svh =====
// Assertion macros for the FIR filter block.
`ifndef FIR_FAST_CONVOLUTION_DEFINES_SVH
`define FIR_FAST_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, checked on clk with reset masking.
`define FFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk with reset masking.
`define FFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ffc_pkg.sv =====
// Shared constants and types for the FIR filter block.
package ffc_pkg;

  localparam int MAX_TAPS = 64;
  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int NT_W     = 7;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = PROD_W + TAP_W;
  localparam int FRAC_W   = 15;
  localparam int Q_W      = ACC_W - FRAC_W;
  localparam int PC_W     = 3;
  localparam int JC_W     = 3;

  localparam logic [NT_W-1:0] TAPS_RESET = NT_W'(MAX_TAPS);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Jump conditions of the microprogram.
  localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
  localparam logic [JC_W-1:0] JC_ALWAYS   = 3'd1;
  localparam logic [JC_W-1:0] JC_IF_LOAD  = 3'd2;
  localparam logic [JC_W-1:0] JC_IF_MORE  = 3'd3;
  localparam logic [JC_W-1:0] JC_WAIT_IN  = 3'd4;
  localparam logic [JC_W-1:0] JC_WAIT_OUT = 3'd5;

  typedef struct packed {
    logic in_rdy;
    logic hist_wr;
    logic issue;
    logic tap_wr;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    ctrl_t            ctrl;
    logic [JC_W-1:0]  jc;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic is_load;
    logic more;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/ffc_seq.sv =====
// Microcoded sequencer: step counter, control store and jump logic.
module ffc_seq import ffc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  localparam int PROG_LEN = 2 ** PC_W;

  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_DISP   = 3'd1;
  localparam logic [PC_W-1:0] PC_HWR    = 3'd2;
  localparam logic [PC_W-1:0] PC_ISSUE  = 3'd3;
  localparam logic [PC_W-1:0] PC_DRAIN0 = 3'd4;
  localparam logic [PC_W-1:0] PC_DRAIN1 = 3'd5;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd6;
  localparam logic [PC_W-1:0] PC_LOAD   = 3'd7;

  // ctrl fields: in_rdy, hist_wr, issue, tap_wr, finish
  localparam uword_t PROGRAM [PROG_LEN] = '{
    '{ctrl: 5'b10000, jc: JC_WAIT_IN,  target: PC_DISP},
    '{ctrl: 5'b00000, jc: JC_IF_LOAD,  target: PC_LOAD},
    '{ctrl: 5'b01000, jc: JC_NEXT,     target: PC_WAIT},
    '{ctrl: 5'b00100, jc: JC_IF_MORE,  target: PC_ISSUE},
    '{ctrl: 5'b00000, jc: JC_NEXT,     target: PC_WAIT},
    '{ctrl: 5'b00000, jc: JC_NEXT,     target: PC_WAIT},
    '{ctrl: 5'b00001, jc: JC_WAIT_OUT, target: PC_WAIT},
    '{ctrl: 5'b00010, jc: JC_ALWAYS,   target: PC_WAIT}
  };

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          word;

  assign word = PROGRAM[pc];

  always_comb begin
    pc_next = pc + PC_W'(1);
    unique case (word.jc)
      JC_NEXT:     pc_next = pc + PC_W'(1);
      JC_ALWAYS:   pc_next = word.target;
      JC_IF_LOAD:  if (status.is_load) pc_next = word.target;
      JC_IF_MORE:  if (status.more) pc_next = word.target;
      JC_WAIT_IN:  pc_next = status.accept ? word.target : pc;
      JC_WAIT_OUT: pc_next = status.out_busy ? pc : word.target;
      default:     pc_next = PC_WAIT;
    endcase
  end

  always_comb begin
    ctrl = word.ctrl;
    // hold the result step until the output register can take it
    ctrl.finish = word.ctrl.finish & ~status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hw/rtl/ffc_datapath.sv =====
// Tap store, sample history, shared multiply-accumulate and output rounding.
module ffc_datapath import ffc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_t                    ctrl,
  input  logic                     accept,
  input  logic                     command,
  input  logic [TAP_W-1:0]         tap_index,
  input  logic signed [DATA_W-1:0] coefficient,
  input  logic signed [DATA_W-1:0] sample,
  input  logic [NT_W-1:0]          taps_in_use,
  output logic                     is_load,
  output logic                     more,
  output logic signed [DATA_W-1:0] result_sample,
  output logic                     result_sat
);

  logic                     cmd_reg;
  logic [TAP_W-1:0]         idx_reg;
  logic signed [DATA_W-1:0] coef_reg;
  logic signed [DATA_W-1:0] samp_reg;

  logic signed [DATA_W-1:0] tap_mem  [MAX_TAPS];
  logic signed [DATA_W-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]      tap_valid;
  logic [MAX_TAPS-1:0]      hist_valid;

  logic [TAP_W-1:0]         k;
  logic [TAP_W-1:0]         wptr;
  logic [TAP_W-1:0]         hist_addr;
  logic [NT_W-1:0]          n_active;

  logic signed [DATA_W-1:0] tap_q;
  logic signed [DATA_W-1:0] hist_q;
  logic                     tap_vq;
  logic                     hist_vq;
  logic                     rd_v;
  logic signed [PROD_W-1:0] prod;
  logic                     mul_v;
  logic signed [ACC_W-1:0]  acc;

  logic signed [DATA_W-1:0] tap_op;
  logic signed [DATA_W-1:0] hist_op;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [Q_W-1:0]    q;
  logic                     in_range;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg  <= command;
      idx_reg  <= tap_index;
      coef_reg <= coefficient;
      samp_reg <= sample;
    end
  end

  assign is_load = (cmd_reg == CMD_LOAD);

  // zero taps acts as one, too many acts as the full store
  always_comb begin
    if (taps_in_use == '0) begin
      n_active = NT_W'(1);
    end else if (taps_in_use > NT_W'(MAX_TAPS)) begin
      n_active = NT_W'(MAX_TAPS);
    end else begin
      n_active = taps_in_use;
    end
  end

  assign more      = ((NT_W'(k) + NT_W'(1)) < n_active);
  assign hist_addr = wptr - k;

  always_ff @(posedge clk) begin
    if (ctrl.tap_wr && (NT_W'(idx_reg) < NT_W'(MAX_TAPS))) begin
      tap_mem[idx_reg] <= coef_reg;
    end
    if (ctrl.hist_wr) begin
      hist_mem[wptr] <= samp_reg;
    end
    tap_q  <= tap_mem[k];
    hist_q <= hist_mem[hist_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid  <= '0;
      hist_valid <= '0;
      wptr       <= '0;
      k          <= '0;
      rd_v       <= 1'b0;
      mul_v      <= 1'b0;
    end else begin
      if (ctrl.tap_wr && (NT_W'(idx_reg) < NT_W'(MAX_TAPS))) begin
        tap_valid[idx_reg] <= 1'b1;
      end
      if (ctrl.hist_wr) begin
        hist_valid[wptr] <= 1'b1;
        k <= '0;
      end else if (ctrl.issue) begin
        k <= k + TAP_W'(1);
      end
      if (ctrl.finish) begin
        wptr <= wptr + TAP_W'(1);
      end
      rd_v  <= ctrl.issue;
      mul_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    tap_vq  <= tap_valid[k];
    hist_vq <= hist_valid[hist_addr];
  end

  // entries never written read as zero
  assign tap_op  = tap_vq ? tap_q : '0;
  assign hist_op = hist_vq ? hist_q : '0;

  always_ff @(posedge clk) begin
    prod <= tap_op * hist_op;
    if (ctrl.hist_wr) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, then clip to Q1.15
  assign rounded  = acc + ACC_W'(1 << (FRAC_W - 1));
  assign q        = rounded[ACC_W-1:FRAC_W];
  assign in_range = (q[Q_W-1:DATA_W-1] == '0) || (q[Q_W-1:DATA_W-1] == '1);

  always_comb begin
    if (in_range) begin
      result_sample = q[DATA_W-1:0];
    end else if (q[Q_W-1]) begin
      result_sample = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      result_sample = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign result_sat = ~in_range;

endmodule

// ===== hw/rtl/fir_fast_convolution.sv =====
// A load is written to the tap store after dispatch; a sample is written to the history, then
// the single shared multiply-accumulate walks the taps one per cycle, drains and rounds into the
// output register. A new transaction is accepted only once the previous one has finished.
// The output register lets the next transaction be accepted while a result waits.
// Reset (rst, synchronous, active high) empties the tap store and sample history
// through per-entry valid bits at once and sets taps_in_use to 64.
`include "fir_fast_convolution_defines.svh"

module fir_fast_convolution import ffc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     command,
  input  logic [TAP_W-1:0]         tap_index,
  input  logic signed [DATA_W-1:0] coefficient,
  input  logic signed [DATA_W-1:0] sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] filtered_sample,
  output logic                     saturated
);

  localparam logic REG_TAPS = 1'b0;

  logic [NT_W-1:0]          taps_in_use;
  ctrl_t                    ctrl;
  status_t                  status;
  logic                     accept;
  logic                     is_load;
  logic                     more;
  logic signed [DATA_W-1:0] result_sample;
  logic                     result_sat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use <= TAPS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TAPS)) begin
      taps_in_use <= pwdata[NT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TAPS) ? {{(32-NT_W){1'b0}}, taps_in_use} : '0;

  assign in_ready = ctrl.in_rdy;
  assign accept   = in_valid & in_ready;

  assign status.accept   = accept;
  assign status.is_load  = is_load;
  assign status.more     = more;
  assign status.out_busy = out_valid & ~out_ready;

  ffc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  ffc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .accept        (accept),
    .command       (command),
    .tap_index     (tap_index),
    .coefficient   (coefficient),
    .sample        (sample),
    .taps_in_use   (taps_in_use),
    .is_load       (is_load),
    .more          (more),
    .result_sample (result_sample),
    .result_sat    (result_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      filtered_sample <= result_sample;
      saturated       <= result_sat;
    end
  end

  `FFC_ASSERT_NEXT(a_leave_wait, accept, !in_ready, "sequencer stayed ready after a transaction")
  `FFC_ASSERT_NOW(a_no_overwrite, ctrl.finish, !status.out_busy, "result overwrote a pending one")
  `FFC_ASSERT_NEXT(a_no_early_result, accept, !ctrl.finish, "result produced right after accept")

endmodule
